### hdl/bmpsr_pkg.sv
`default_nettype none

package bmpsr_pkg;

	localparam int unsigned MAX_DIM = 4096;
	// bits needed to hold a dimension up to MAX_DIM
	localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);

	localparam int unsigned HEADER_BYTES = 54;
	localparam int unsigned WIDTH_POS = 18;
	localparam int unsigned HEIGHT_POS = 22;
	localparam int unsigned POS_W = $clog2(HEADER_BYTES);

	localparam logic [7:0] SIG_B = 8'h42;
	localparam logic [7:0] SIG_M = 8'h4D;

	typedef enum logic [1:0] {
		KIND_PIXEL = 2'd0,
		KIND_HEADER_OK = 2'd1,
		KIND_BAD_SIG = 2'd2,
		KIND_BAD_DIM = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_PIXEL = 2'd1,
		PH_IDLE = 2'd2
	} phase_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [11:0] col;
		logic [11:0] row;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic last_pixel;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} push_t;

	function automatic logic dim_bad(input logic [31:0] d);
		dim_bad = d[31] || (d > 32'(MAX_DIM));
	endfunction

endpackage

`default_nettype wire

### hdl/bmpsr_parser.sv
`default_nettype none

module bmpsr_parser (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic accept,
	input wire logic [7:0] byte_value,
	input wire logic start_of_file,
	output bmpsr_pkg::push_t push
);

	localparam int unsigned DW = bmpsr_pkg::DIM_W;
	localparam logic [bmpsr_pkg::POS_W-1:0] POS_W_ONE = 1;
	localparam logic [bmpsr_pkg::POS_W-1:0] POS_LAST = bmpsr_pkg::POS_W'(bmpsr_pkg::HEADER_BYTES - 1);
	localparam logic [bmpsr_pkg::POS_W-1:0] POS_WID = bmpsr_pkg::POS_W'(bmpsr_pkg::WIDTH_POS);
	localparam logic [bmpsr_pkg::POS_W-1:0] POS_HGT = bmpsr_pkg::POS_W'(bmpsr_pkg::HEIGHT_POS);

	bmpsr_pkg::phase_t phase_q, phase_e, phase_n;
	logic [bmpsr_pkg::POS_W-1:0] pos_q, pos_e, pos_n;
	logic [31:0] width_q, width_e, width_n;
	logic [31:0] height_q, height_e, height_n;
	logic [DW-1:0] col_q, col_e, col_n;
	logic [DW-1:0] row_q, row_e, row_n;
	logic [1:0] chan_q, chan_e, chan_n;
	logic [7:0] blue_q, blue_e, blue_n;
	logic [7:0] green_q, green_e, green_n;
	logic [1:0] pad_q, pad_e, pad_n;

	logic sig_bad, hdr_last, in_width, in_height, dims_bad;
	logic [1:0] wbyte, hbyte;
	logic [DW-1:0] col_inc, row_inc;
	logic row_end, img_end;

	// start mark clears the parse before this byte is looked at
	always_comb begin
		if (start_of_file) begin
			phase_e = bmpsr_pkg::PH_HEADER;
			pos_e = '0;
			width_e = '0;
			height_e = '0;
			col_e = '0;
			row_e = '0;
			chan_e = '0;
			blue_e = '0;
			green_e = '0;
			pad_e = '0;
		end else begin
			phase_e = phase_q;
			pos_e = pos_q;
			width_e = width_q;
			height_e = height_q;
			col_e = col_q;
			row_e = row_q;
			chan_e = chan_q;
			blue_e = blue_q;
			green_e = green_q;
			pad_e = pad_q;
		end
	end

	assign sig_bad = (pos_e == '0 && byte_value != bmpsr_pkg::SIG_B) ||
		(pos_e == POS_W_ONE && byte_value != bmpsr_pkg::SIG_M);

	assign hdr_last = (pos_e == POS_LAST);
	assign in_width = (pos_e >= POS_WID) && (pos_e < POS_WID + 4);
	assign in_height = (pos_e >= POS_HGT) && (pos_e < POS_HGT + 4);
	assign wbyte = 2'(pos_e - POS_WID);
	assign hbyte = 2'(pos_e - POS_HGT);
	assign dims_bad = bmpsr_pkg::dim_bad(width_e) || bmpsr_pkg::dim_bad(height_e);

	// in the pixel phase both dimensions fit in DW bits
	assign col_inc = col_e + 1'b1;
	assign row_inc = row_e + 1'b1;
	assign row_end = (col_inc >= width_e[DW-1:0]);
	assign img_end = row_end && (row_inc >= height_e[DW-1:0]);

	// next state
	always_comb begin
		phase_n = phase_e;
		pos_n = pos_e;
		width_n = width_e;
		height_n = height_e;
		col_n = col_e;
		row_n = row_e;
		chan_n = chan_e;
		blue_n = blue_e;
		green_n = green_e;
		pad_n = pad_e;
		unique case (phase_e)
			bmpsr_pkg::PH_HEADER: begin
				pos_n = pos_e + 1'b1;
				if (sig_bad) begin
					phase_n = bmpsr_pkg::PH_IDLE;
				end else begin
					if (in_width) begin
						width_n[{wbyte, 3'b000} +: 8] = width_e[{wbyte, 3'b000} +: 8] | byte_value;
					end
					if (in_height) begin
						height_n[{hbyte, 3'b000} +: 8] =
							height_e[{hbyte, 3'b000} +: 8] | byte_value;
					end
					if (hdr_last) begin
						if (dims_bad || width_e == '0 || height_e == '0) begin
							phase_n = bmpsr_pkg::PH_IDLE;
						end else begin
							phase_n = bmpsr_pkg::PH_PIXEL;
						end
					end
				end
			end
			bmpsr_pkg::PH_PIXEL: begin
				if (pad_e != '0) begin
					pad_n = pad_e - 1'b1;
				end else if (chan_e == 2'd0) begin
					blue_n = byte_value;
					chan_n = 2'd1;
				end else if (chan_e == 2'd1) begin
					green_n = byte_value;
					chan_n = 2'd2;
				end else begin
					chan_n = 2'd0;
					if (row_end) begin
						col_n = '0;
						row_n = row_inc;
						if (img_end) begin
							phase_n = bmpsr_pkg::PH_IDLE;
						end else begin
							pad_n = width_e[1:0];
						end
					end else begin
						col_n = col_inc;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result for this byte
	always_comb begin
		push = '0;
		unique case (phase_e)
			bmpsr_pkg::PH_HEADER: begin
				if (sig_bad) begin
					push.valid = accept;
					push.res.kind = bmpsr_pkg::KIND_BAD_SIG;
				end else if (hdr_last) begin
					push.valid = accept;
					if (dims_bad) begin
						push.res.kind = bmpsr_pkg::KIND_BAD_DIM;
					end else begin
						push.res.kind = bmpsr_pkg::KIND_HEADER_OK;
						push.res.image_width = width_e[12:0];
						push.res.image_height = height_e[12:0];
					end
				end
			end
			bmpsr_pkg::PH_PIXEL: begin
				if (pad_e == '0 && chan_e != 2'd0 && chan_e != 2'd1) begin
					push.valid = accept;
					push.res.kind = bmpsr_pkg::KIND_PIXEL;
					push.res.red = byte_value;
					push.res.green = green_e;
					push.res.blue = blue_e;
					push.res.col = col_e[11:0];
					push.res.row = row_e[11:0];
					push.res.last_pixel = img_end;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bmpsr_pkg::PH_HEADER;
			pos_q <= '0;
			width_q <= '0;
			height_q <= '0;
			col_q <= '0;
			row_q <= '0;
			chan_q <= '0;
			blue_q <= '0;
			green_q <= '0;
			pad_q <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			pos_q <= pos_n;
			width_q <= width_n;
			height_q <= height_n;
			col_q <= col_n;
			row_q <= row_n;
			chan_q <= chan_n;
			blue_q <= blue_n;
			green_q <= green_n;
			pad_q <= pad_n;
		end
	end

endmodule

`default_nettype wire

### hdl/bmpsr_outbuf.sv
`default_nettype none

module bmpsr_outbuf (
	input wire logic clk,
	input wire logic arst_n,
	input wire bmpsr_pkg::push_t push,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output bmpsr_pkg::res_t res
);

	logic main_v_q, skid_v_q;
	bmpsr_pkg::res_t main_q, skid_q;
	logic pop;

	assign pop = main_v_q && out_ready;
	// ready is a register: only a full skid stage holds off the sender
	assign in_ready = !skid_v_q;
	assign out_valid = main_v_q;
	assign res = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || pop) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push.valid;
			end
		end else if (push.valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || pop) begin
			main_q <= skid_v_q ? skid_q : push.res;
		end else if (push.valid) begin
			skid_q <= push.res;
		end
	end

endmodule

`default_nettype wire

### hdl/bmp_stream_reader.sv
// Streaming reader for 24-bit BMP files.
// Input channel (in_valid/in_ready): one file byte per item in byte_value;
// start_of_file marks the first byte of a file and restarts the parse.
// Output channel (out_valid/out_ready): at most one result per input byte.
// kind selects pixel, header accepted, bad signature or dimension too large;
// pixels come with col/row and last_pixel, header results with image size.
// The parse state updates in the cycle a byte is accepted; its result is
// registered in the output buffer before it shows on the output.
// Throughput is one byte per clock while in_ready is high. A two-entry
// output buffer (result plus skid register) sits in front of the output, so
// in_ready is a register and drops only when both entries hold results the
// receiver has not taken. A stalled receiver therefore stops input two
// results later; bytes that produce no result still need in_ready.
// Reset puts the parser at header byte 0 and empties the output buffer.
// After an error or the last pixel, bytes are dropped until start_of_file.
`default_nettype none

module bmp_stream_reader (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] byte_value,
	input wire logic start_of_file,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] kind,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [11:0] col,
	output logic [11:0] row,
	output logic [12:0] image_width,
	output logic [12:0] image_height,
	output logic last_pixel
);

	bmpsr_pkg::push_t push;
	bmpsr_pkg::res_t res;
	logic accept;

	assign accept = in_valid && in_ready;

	bmpsr_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.byte_value(byte_value),
		.start_of_file(start_of_file),
		.push(push)
	);

	bmpsr_outbuf u_outbuf (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res(res)
	);

	assign kind = res.kind;
	assign red = res.red;
	assign green = res.green;
	assign blue = res.blue;
	assign col = res.col;
	assign row = res.row;
	assign image_width = res.image_width;
	assign image_height = res.image_height;
	assign last_pixel = res.last_pixel;

	// skid entry only fills behind a held result
	a_ready_low_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	a_ready_falls_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("input ready dropped without an output stall");

	a_header_size_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && push.res.kind == bmpsr_pkg::KIND_HEADER_OK) |->
		(push.res.image_width <= 13'(bmpsr_pkg::MAX_DIM) &&
		 push.res.image_height <= 13'(bmpsr_pkg::MAX_DIM)))
		else $error("accepted header with oversized dimension");

	a_result_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> accept)
		else $error("result produced without an accepted item");

endmodule

`default_nettype wire

### dv/tb_bmp_stream_reader.sv
`timescale 1ns / 100ps

import bmpsr_pkg::*;

// Tracks the decode of the byte stream and holds the results still owed by the block.
class bmp_decode_board;
	res_t owed[$];
	int unsigned failures;

	phase_t stage;
	int unsigned hdr_idx;
	logic [31:0] width_le;
	logic [31:0] height_le;
	logic [31:0] x_count;
	logic [31:0] y_count;
	logic [1:0] byte_phase;
	logic [7:0] blue_hold;
	logic [7:0] green_hold;
	logic [1:0] pad_skip;

	function new();
		failures = 0;
		restart_parse();
	endfunction

	function void restart_parse();
		stage = PH_HEADER;
		hdr_idx = 0;
		width_le = '0;
		height_le = '0;
		x_count = '0;
		y_count = '0;
		byte_phase = '0;
		blue_hold = '0;
		green_hold = '0;
		pad_skip = '0;
	endfunction

	// Returns 1 when the byte is actually parsed (not dropped while idle).
	function bit note_byte(input logic [7:0] b, input logic sof);
		res_t r;
		int unsigned pos;
		bit used;
		r = '0;
		if (sof)
			restart_parse();
		used = (stage != PH_IDLE);
		if (stage == PH_HEADER) begin
			pos = hdr_idx;
			hdr_idx++;
			if ((pos == 0 && b != SIG_B) || (pos == 1 && b != SIG_M)) begin
				stage = PH_IDLE;
				r.kind = KIND_BAD_SIG;
				owed.push_back(r);
				return used;
			end
			if (pos >= WIDTH_POS && pos < WIDTH_POS + 4)
				width_le |= 32'(b) << (8 * (pos - WIDTH_POS));
			else if (pos >= HEIGHT_POS && pos < HEIGHT_POS + 4)
				height_le |= 32'(b) << (8 * (pos - HEIGHT_POS));
			if (pos == HEADER_BYTES - 1) begin
				if (dims_out_of_range(width_le) || dims_out_of_range(height_le)) begin
					stage = PH_IDLE;
					r.kind = KIND_BAD_DIM;
				end else begin
					if (width_le == 0 || height_le == 0)
						stage = PH_IDLE;
					else
						stage = PH_PIXEL;
					r.kind = KIND_HEADER_OK;
					r.image_width = width_le[12:0];
					r.image_height = height_le[12:0];
				end
				owed.push_back(r);
			end
			return used;
		end
		if (stage != PH_PIXEL)
			return used;
		if (pad_skip != 0) begin
			pad_skip--;
			return used;
		end
		if (byte_phase == 0) begin
			blue_hold = b;
			byte_phase = 1;
			return used;
		end
		if (byte_phase == 1) begin
			green_hold = b;
			byte_phase = 2;
			return used;
		end
		byte_phase = 0;
		r.kind = KIND_PIXEL;
		r.red = b;
		r.green = green_hold;
		r.blue = blue_hold;
		r.col = x_count[11:0];
		r.row = y_count[11:0];
		x_count++;
		if (x_count >= width_le) begin
			x_count = 0;
			y_count++;
			if (y_count >= height_le) begin
				r.last_pixel = 1'b1;
				stage = PH_IDLE;
			end else begin
				pad_skip = width_le[1:0];
			end
		end
		owed.push_back(r);
		return used;
	endfunction

	// negative as signed 32 bits, or larger than MAX_DIM
	function bit dims_out_of_range(input logic [31:0] d);
		return d[31] || d > MAX_DIM;
	endfunction

	function void report(input string what, input logic [31:0] want, input logic [31:0] got);
		failures++;
		if (failures <= 40)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
	endfunction

	function void check_result(input res_t got);
		res_t want;
		if (owed.size() == 0) begin
			failures++;
			if (failures <= 40)
				$display("%0t: unexpected result, expected none, got kind %0d",
					$time, got.kind);
			return;
		end
		want = owed.pop_front();
		if (got.kind !== want.kind) report("kind", want.kind, got.kind);
		if (got.red !== want.red) report("red", want.red, got.red);
		if (got.green !== want.green) report("green", want.green, got.green);
		if (got.blue !== want.blue) report("blue", want.blue, got.blue);
		if (got.col !== want.col) report("col", want.col, got.col);
		if (got.row !== want.row) report("row", want.row, got.row);
		if (got.image_width !== want.image_width)
			report("image_width", want.image_width, got.image_width);
		if (got.image_height !== want.image_height)
			report("image_height", want.image_height, got.image_height);
		if (got.last_pixel !== want.last_pixel)
			report("last_pixel", want.last_pixel, got.last_pixel);
	endfunction
endclass

module tb_bmp_stream_reader;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned TAIL_CYCLES = 20;
	localparam int unsigned ITEM_COUNT = 1700;
	localparam int unsigned MIN_FILES = 10;
	localparam logic [31:0] NO_CUT = 32'hFFFF_FFFF;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] byte_value;
	logic start_of_file;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [11:0] col;
	logic [11:0] row;
	logic [12:0] image_width;
	logic [12:0] image_height;
	logic last_pixel;

	bmp_decode_board board;
	bit calm = 1'b0;
	int unsigned hold_requests = 0;
	int unsigned hold_taken = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;
	int unsigned sent_bytes = 0;

	bmp_stream_reader uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_value(byte_value),
		.start_of_file(start_of_file),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.red(red),
		.green(green),
		.blue(blue),
		.col(col),
		.row(row),
		.image_width(image_width),
		.image_height(image_height),
		.last_pixel(last_pixel)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_taken != hold_requests) begin
			hold_taken = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 33);
		end
	end

	always @(posedge clk) begin
		res_t seen;
		if (arst_n && out_valid && out_ready) begin
			seen.kind = kind_t'(kind);
			seen.red = red;
			seen.green = green;
			seen.blue = blue;
			seen.col = col;
			seen.row = row;
			seen.image_width = image_width;
			seen.image_height = image_height;
			seen.last_pixel = last_pixel;
			board.check_result(seen);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic sof);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		byte_value <= b;
		start_of_file <= sof;
		do
			@(posedge clk);
		while (!in_ready);
		sent_bytes++;
		void'(board.note_byte(b, sof));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.owed.size() != 0)
			@(posedge clk);
	endtask

	// Header with the given signature and size, then random pixel and pad bytes for a
	// well-formed image of valid size, cut short after cut bytes, then tail stray bytes.
	task automatic send_file(input logic [31:0] w, input logic [31:0] h,
		input logic [7:0] sig0, input logic [7:0] sig1, input bit mark,
		input logic [31:0] cut, input int unsigned tail);
		int unsigned body;
		int unsigned len;
		logic [7:0] b;
		body = 0;
		if (w >= 1 && w <= MAX_DIM && h >= 1 && h <= MAX_DIM)
			body = h * (3 * w + w % 4);
		len = HEADER_BYTES + body;
		if (cut < len)
			len = cut;
		for (int unsigned i = 0; i < len + tail; i++) begin
			b = 8'($urandom);
			if (i == 0)
				b = sig0;
			else if (i == 1)
				b = sig1;
			else if (i >= WIDTH_POS && i < WIDTH_POS + 4)
				b = w[8 * (i - WIDTH_POS) +: 8];
			else if (i >= HEIGHT_POS && i < HEIGHT_POS + 4)
				b = h[8 * (i - HEIGHT_POS) +: 8];
			send_byte(b, mark && i == 0);
		end
	endtask

	function automatic logic [7:0] not_this(input logic [7:0] avoid);
		logic [7:0] v;
		v = 8'($urandom);
		if (v == avoid)
			v = ~v;
		return v;
	endfunction

	initial begin
		int unsigned file_idx;
		int unsigned pick;
		logic [31:0] w;
		logic [31:0] h;
		logic [31:0] big;
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_value = '0;
		start_of_file = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// header parsed straight out of reset, no start mark
		send_file(2, 2, SIG_B, SIG_M, 1'b0, NO_CUT, 2);
		send_file(3, 1, 8'h00, SIG_M, 1'b1, 5, 0);
		send_file(3, 1, SIG_B, 8'hFF, 1'b1, 6, 2);
		send_file(MAX_DIM + 1, 1, SIG_B, SIG_M, 1'b1, NO_CUT, 1);
		send_file(1, 32'h8000_0000, SIG_B, SIG_M, 1'b1, NO_CUT, 0);
		send_file(32'hFFFF_FFFF, 32'hFFFF_FFFF, SIG_B, SIG_M, 1'b1, NO_CUT, 0);
		send_file(0, 3, SIG_B, SIG_M, 1'b1, NO_CUT, 2);
		send_file(MAX_DIM, 0, SIG_B, SIG_M, 1'b1, NO_CUT, 1);
		// start mark in the middle of the header and then mid image
		send_file(5, 3, SIG_B, SIG_M, 1'b1, 30, 0);
		send_file(5, 3, SIG_B, SIG_M, 1'b1, HEADER_BYTES + 20, 0);
		send_file(3, 2, SIG_B, SIG_M, 1'b1, NO_CUT, 4);
		// widest row and tallest column, cut short
		send_file(MAX_DIM, 1, SIG_B, SIG_M, 1'b1, HEADER_BYTES + 30, 0);
		send_file(1, MAX_DIM, SIG_B, SIG_M, 1'b1, HEADER_BYTES + 30, 0);

		file_idx = 0;
		while (sent_bytes < ITEM_COUNT || file_idx < MIN_FILES) begin
			calm = (file_idx >= 5 && file_idx < 9);
			w = $urandom_range(1, 9);
			h = $urandom_range(1, 4);
			if ($urandom_range(19) == 0)
				w = $urandom_range(10, 64);
			pick = $urandom_range(99);
			if (file_idx == 1) begin
				// block fills up while the receiver holds off
				hold_requests++;
				send_file(8, 4, SIG_B, SIG_M, 1'b1, NO_CUT, 0);
			end else if (file_idx == 3) begin
				wait_drained();
				send_file(w, h, SIG_B, SIG_M, 1'b1, NO_CUT, 0);
			end else if (pick < 70) begin
				send_file(w, h, SIG_B, SIG_M, 1'b1, NO_CUT,
					$urandom_range(3) == 0 ? $urandom_range(1, 4) : 0);
			end else if (pick < 78) begin
				send_file(w, h, SIG_B, SIG_M, 1'b1,
					$urandom_range(1, HEADER_BYTES + h * (3 * w + w % 4) - 1), 0);
			end else if (pick < 84) begin
				if ($urandom_range(1) == 0)
					send_file(w, h, not_this(SIG_B), SIG_M, 1'b1,
						$urandom_range(1, 60), 0);
				else
					send_file(w, h, SIG_B, not_this(SIG_M), 1'b1,
						$urandom_range(2, 60), 0);
			end else if (pick < 90) begin
				big = $urandom;
				if (big <= MAX_DIM)
					big = big + MAX_DIM + 1;
				if ($urandom_range(1) == 0)
					send_file(big, h, SIG_B, SIG_M, 1'b1, NO_CUT, $urandom_range(3));
				else
					send_file(w, big, SIG_B, SIG_M, 1'b1, NO_CUT, $urandom_range(3));
			end else if (pick < 95) begin
				if ($urandom_range(1) == 0)
					send_file(0, h, SIG_B, SIG_M, 1'b1, NO_CUT, $urandom_range(3));
				else
					send_file(w, 0, SIG_B, SIG_M, 1'b1, NO_CUT, $urandom_range(3));
			end else begin
				// stray bytes with no start mark
				repeat ($urandom_range(1, 8))
					send_byte(8'($urandom), 1'b0);
			end
			file_idx++;
		end
		calm = 1'b0;

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.failures == 0 && board.owed.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
